// ===== sv/bsrf_pkg.sv =====
// Shared types and constants for the battery slew-rate failsafe block.
package bsrf_pkg;

  // Field and register widths
  localparam int unsigned LEVEL_W  = 15;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned RETRY_W  = 8;
  localparam int unsigned PERIOD_W = 22;
  localparam int unsigned CFG_W    = 22;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_PERIOD = 2'd2;

  // Register reset values
  localparam logic [LEVEL_W-1:0]  RATE_LIMIT_RST   = 15'd100;
  localparam logic [RETRY_W-1:0]  MAX_RETRIES_RST  = 8'd3;
  localparam logic [PERIOD_W-1:0] CHECK_PERIOD_RST = 22'd60000;

  // Input kind codes
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_LEVEL = 1'b1;

  // Status from the shared divider to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/bsrf_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface bsrf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [bsrf_pkg::ACC_W-1:0]    elapsed_ms;
  logic [bsrf_pkg::LEVEL_W-1:0]  level_mv;

  modport source (output valid, kind, elapsed_ms, level_mv, input ready);
  modport sink   (input valid, kind, elapsed_ms, level_mv, output ready);
endinterface

interface bsrf_out_if;
  logic                          valid;
  logic                          ready;
  logic                          checked;
  logic [bsrf_pkg::LEVEL_W-1:0]  rate_mv_per_min;
  logic [bsrf_pkg::RETRY_W-1:0]  retry_cnt;
  logic                          fail_now;
  logic                          failed;

  modport source (output valid, checked, rate_mv_per_min, retry_cnt, fail_now, failed,
                  input ready);
  modport sink   (input valid, checked, rate_mv_per_min, retry_cnt, fail_now, failed,
                  output ready);
endinterface

// ===== sv/battery_slew_rate_failsafe_top.sv =====
// Top level of the battery slew-rate failsafe: sequencer, state and result register.
//
// Tick items add elapsed milliseconds to a saturating 32-bit accumulator; level
// items prime a baseline and, once the accumulator reaches the check period, run
// a rate check. An item that does no check goes from EVAL straight to DONE,
// where the result register is loaded. A check runs two divisions, minutes =
// acc / period and rate = |level - baseline| / minutes, one after the other on a
// single shared restoring divider that yields one quotient bit per cycle, in
// S_DIV_MIN and S_DIV_RATE. The input is not ready while an item is in work, and
// is ready again while a finished result still waits to be taken.
module battery_slew_rate_failsafe_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bsrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsrf_pkg::CFG_W-1:0]      cfg_data,
  bsrf_in_if.sink                         in_ch,
  bsrf_out_if.source                      out_ch
);
  import bsrf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_EVAL     = 5'b00010,
    S_DIV_MIN  = 5'b00100,
    S_DIV_RATE = 5'b01000,
    S_DONE     = 5'b10000
  } state_t;

  state_t state, state_next;

  // Configuration registers
  logic [LEVEL_W-1:0]  rate_limit;
  logic [RETRY_W-1:0]  max_retries;
  logic [PERIOD_W-1:0] check_period;

  // Block state
  logic               primed;
  logic [LEVEL_W-1:0] baseline_mv;
  logic [ACC_W-1:0]   time_acc;
  logic [RETRY_W-1:0] retries;
  logic               fail_latched;

  // Captured transaction and check result
  logic               kind_r;
  logic [ACC_W-1:0]   elapsed_r;
  logic [LEVEL_W-1:0] level_r;
  logic               chk_r;
  logic [LEVEL_W-1:0] rate_r;

  // Output register
  logic               out_valid;
  logic               out_checked;
  logic [LEVEL_W-1:0] out_rate;
  logic [RETRY_W-1:0] out_retry;
  logic               out_fail_now;
  logic               out_failed;

  // Divider hookup
  logic               div_start;
  logic [ACC_W-1:0]   div_dividend;
  logic [ACC_W-1:0]   div_divisor;
  logic [ACC_W-1:0]   div_quo;
  div_stat_t          div_stat;

  logic [ACC_W-1:0]   period;
  logic [ACC_W:0]     acc_sum;
  logic [LEVEL_W-1:0] level_diff;
  logic               out_free;
  logic               over_limit;
  logic [RETRY_W:0]   retry_inc;
  logic               fail_hit;

  // Treat a zero period as one millisecond
  assign period     = (check_period == '0) ? ACC_W'(1) : ACC_W'(check_period);
  assign acc_sum    = {1'b0, time_acc} + {1'b0, elapsed_r};
  assign level_diff = (level_r >= baseline_mv) ? (level_r - baseline_mv)
                                               : (baseline_mv - level_r);
  assign out_free   = !out_valid || out_ch.ready;

  // Retry decision for a completed check
  assign over_limit = (rate_r > rate_limit);
  assign retry_inc  = (retries == {RETRY_W{1'b1}}) ? {1'b0, retries}
                                                   : {1'b0, retries} + (RETRY_W+1)'(1);
  assign fail_hit   = over_limit && (retry_inc > {1'b0, max_retries});

  // Shared divider operands: minutes first, then the rate
  assign div_start    = ((state == S_EVAL) && kind_r == KIND_LEVEL && primed
                         && time_acc >= period)
                        || ((state == S_DIV_MIN) && div_stat.done);
  assign div_dividend = (state == S_DIV_MIN) ? ACC_W'(level_diff) : time_acc;
  assign div_divisor  = (state == S_DIV_MIN) ? div_quo : period;

  bsrf_div #(.W(ACC_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_ch.valid) state_next = S_EVAL;
      S_EVAL:     state_next = div_start ? S_DIV_MIN : S_DONE;
      S_DIV_MIN:  if (div_stat.done) state_next = S_DIV_RATE;
      S_DIV_RATE: if (div_stat.done) state_next = S_DONE;
      S_DONE:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Hold off the input during reset and while an item is in work
  assign in_ch.ready = (state == S_IDLE) && !rst;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_limit   <= RATE_LIMIT_RST;
      max_retries  <= MAX_RETRIES_RST;
      check_period <= CHECK_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RATE_LIMIT:   rate_limit   <= cfg_data[LEVEL_W-1:0];
        REG_MAX_RETRIES:  max_retries  <= cfg_data[RETRY_W-1:0];
        REG_CHECK_PERIOD: check_period <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      kind_r    <= in_ch.kind;
      elapsed_r <= in_ch.elapsed_ms;
      level_r   <= in_ch.level_mv;
    end
  end

  // Check flag and rate
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_r <= 1'b0;
    end else if (state == S_EVAL) begin
      chk_r <= div_start;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      rate_r <= '0;
    end else if (state == S_DIV_RATE && div_stat.done) begin
      rate_r <= div_quo[LEVEL_W-1:0];
    end
  end

  // Block state: ticks and priming in EVAL, check outcome in DONE
  always_ff @(posedge clk) begin
    if (rst) begin
      primed       <= 1'b0;
      baseline_mv  <= '0;
      time_acc     <= '0;
      retries      <= '0;
      fail_latched <= 1'b0;
    end else if (state == S_EVAL) begin
      if (kind_r == KIND_TICK) begin
        time_acc <= acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
      end else if (!primed) begin
        primed      <= 1'b1;
        baseline_mv <= level_r;
        time_acc    <= '0;
      end
    end else if (state == S_DONE && out_free && chk_r) begin
      baseline_mv <= level_r;
      time_acc    <= '0;
      if (!over_limit || fail_hit) begin
        retries <= '0;
      end else begin
        retries <= retry_inc[RETRY_W-1:0];
      end
      if (fail_hit) fail_latched <= 1'b1;
    end
  end

  // Output register: load in DONE, drop on acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_checked  <= chk_r;
      out_rate     <= chk_r ? rate_r : '0;
      out_fail_now <= chk_r && fail_hit;
      out_failed   <= fail_latched || (chk_r && fail_hit);
      if (!chk_r) begin
        out_retry <= retries;
      end else if (!over_limit || fail_hit) begin
        out_retry <= '0;
      end else begin
        out_retry <= retry_inc[RETRY_W-1:0];
      end
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.checked         = out_checked;
  assign out_ch.rate_mv_per_min = out_rate;
  assign out_ch.retry_cnt       = out_retry;
  assign out_ch.fail_now        = out_fail_now;
  assign out_ch.failed          = out_failed;

endmodule

// ===== sv/bsrf_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module bsrf_div #(
  parameter int unsigned W = bsrf_pkg::ACC_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [W-1:0]           dividend,
  input  logic [W-1:0]           divisor,
  output logic [W-1:0]           quotient,
  output bsrf_pkg::div_stat_t    stat
);
  import bsrf_pkg::*;

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [W:0]       shifted;
  logic [W:0]       sub;
  logic             ge;

  // Shift in the next dividend bit and trial-subtract the divisor
  assign shifted = {rem, quo[W-1]};
  assign sub     = shifted - {1'b0, dvs};
  assign ge      = (shifted >= {1'b0, dvs});

  // Step the division
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? sub[W-1:0] : shifted[W-1:0];
      quo <= {quo[W-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== sv/bsrf_checker.sv =====
// Port-level checks for the battery slew-rate failsafe, bound to the top level.
module bsrf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_checked,
  input logic [bsrf_pkg::LEVEL_W-1:0]   out_rate,
  input logic [bsrf_pkg::RETRY_W-1:0]   out_retry,
  input logic                           out_fail_now,
  input logic                           out_failed
);
  import bsrf_pkg::*;

  // One transaction in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted transaction");

  // A declared failure is latched
  a_fail_latches: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_fail_now |-> out_failed)
    else $error("fail_now without failed");

  // A declared failure clears the retry count
  a_fail_clears_retry: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_fail_now |-> out_retry == '0)
    else $error("retry count not cleared on failure");

  // Only a check declares a failure
  a_fail_needs_check: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_fail_now |-> out_checked)
    else $error("failure without a check");

  // No rate without a check
  a_rate_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_checked |-> out_rate == '0)
    else $error("nonzero rate without a check");

endmodule

bind battery_slew_rate_failsafe_top bsrf_checker u_bsrf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_checked  (out_ch.checked),
  .out_rate     (out_ch.rate_mv_per_min),
  .out_retry    (out_ch.retry_cnt),
  .out_fail_now (out_ch.fail_now),
  .out_failed   (out_ch.failed)
);
